### rtl/krm_pkg.sv
package krm_pkg;

    localparam int MAX_KNOCKS_DEF    = 14;
    localparam int INTERVAL_BITS_DEF = 16;

    localparam int PATTERN_ENTRIES = 14;
    localparam int PATTERN_SLOTS   = 7;
    localparam int ENTRY_BITS      = 7;
    localparam int PATTERN_BITS    = 49;
    localparam int CFG_DATA_BITS   = 49;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [6:0] SCALE_TOP   = 7'd100;
    localparam int         NORMAL_MANY = 4;
    localparam int         NORMAL_FEW  = 3;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_ENTRY_REJ  = 3'd1;
    localparam logic [2:0] REG_AVG_REJ    = 3'd2;
    localparam logic [2:0] REG_FADE       = 3'd3;
    localparam logic [2:0] REG_COMPLETE   = 3'd4;
    localparam logic [2:0] REG_PATTERN_LO = 3'd5;
    localparam logic [2:0] REG_PATTERN_HI = 3'd6;

    localparam logic [9:0]  THRESHOLD_RST  = 10'd18;
    localparam logic [6:0]  ENTRY_REJ_RST  = 7'd25;
    localparam logic [6:0]  AVG_REJ_RST    = 7'd15;
    localparam logic [15:0] FADE_RST       = 16'd200;
    localparam logic [15:0] COMPLETE_RST   = 16'd1200;
    localparam logic [48:0] PATTERN_LO_RST = 49'd1744935734450;
    localparam logic [48:0] PATTERN_HI_RST = 49'd0;

    // verdict codes
    localparam logic [1:0] VERDICT_REJECT = 2'd0;
    localparam logic [1:0] VERDICT_SECRET = 2'd1;
    localparam logic [1:0] VERDICT_NORMAL = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [6:0] pattern_entry(
        input logic [48:0] lo,
        input logic [48:0] hi,
        input logic [5:0]  idx
    );
        logic [48:0] sh;
        sh = '0;
        if (idx < 6'(PATTERN_SLOTS))
        begin
            sh = lo >> (ENTRY_BITS * int'(idx));
        end
        else if (idx < 6'(PATTERN_ENTRIES))
        begin
            sh = hi >> (ENTRY_BITS * (int'(idx) - PATTERN_SLOTS));
        end
        return sh[6:0];
    endfunction

endpackage

### rtl/krm_div.sv
module krm_div #(
    parameter int INTERVAL_BITS = krm_pkg::INTERVAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [INTERVAL_BITS+6:0]      dividend,
    input  logic [INTERVAL_BITS-1:0]      divisor,
    output logic [6:0]                    quotient,
    output krm_pkg::div_stat_t            stat
);

    localparam int DW = INTERVAL_BITS + 7;
    localparam int CW = $clog2(DW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [INTERVAL_BITS:0]   rem_reg;
    logic [DW-1:0]            quo_reg;
    logic [INTERVAL_BITS-1:0] dsor_reg;

    logic [INTERVAL_BITS:0] shifted;
    logic [INTERVAL_BITS:0] trial;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg[INTERVAL_BITS-1:0], quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[INTERVAL_BITS] ? shifted : trial;
            quo_reg <= {quo_reg[DW-2:0], ~trial[INTERVAL_BITS]};
        end
    end

    assign quotient  = quo_reg[6:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/knock_rhythm_matcher_top.sv
// Knock rhythm matcher. Each input word (sample, now_ms) is one tick; ticks at or above the
// threshold are knocks that open a session or, past the fade time, record an interval. A
// tick that ends a session (quiet for complete_ms, or MAX_KNOCKS intervals) starts an
// evaluation during which in_stall is high: a scan over the stores, then per interval one
// bit-serial division by the largest interval (skipped for zero intervals) and an entry check
// that ends the evaluation on a deviation above entry_rej, then the average check. A mismatch
// on counts ends after the scan. Ticks that end no session do not stall the input. One
// result word (verdict, knock_count) is held until taken.
module knock_rhythm_matcher_top #(
    parameter int MAX_KNOCKS    = krm_pkg::MAX_KNOCKS_DEF,
    parameter int INTERVAL_BITS = krm_pkg::INTERVAL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  sample,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [3:0]  knock_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [krm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [krm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int IW  = $clog2(MAX_KNOCKS + 1);
    localparam int IXW = (MAX_KNOCKS > 1) ? $clog2(MAX_KNOCKS) : 1;
    localparam int SUMW = 10 + IW;
    localparam int TW   = 7 + IW;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CHECK, S_DIV_START, S_DIV_WAIT, S_ENTRY, S_AVG, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [9:0]  thr_reg;
    logic [6:0]  entry_rej_reg;
    logic [6:0]  avg_rej_reg;
    logic [15:0] fade_reg;
    logic [15:0] complete_reg;
    logic [48:0] pat_lo_reg;
    logic [48:0] pat_hi_reg;

    // session
    logic              listening_reg;
    logic [IW-1:0]     count_reg;
    logic [31:0]       last_reg;
    logic [INTERVAL_BITS-1:0] ist_reg [MAX_KNOCKS];
    logic [9:0]               sst_reg [MAX_KNOCKS+1];

    // evaluation
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            heard_reg;
    logic [IW-1:0]            wanted_reg;
    logic [INTERVAL_BITS-1:0] largest_reg;
    logic [SUMW-1:0]          sum_reg;
    logic [TW-1:0]            total_reg;
    logic [6:0]               scaled_reg;
    logic                     match_reg;

    logic        out_valid_reg;
    logic [1:0]  verdict_reg;
    logic [3:0]  knock_count_reg;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign knock_count = knock_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= krm_pkg::THRESHOLD_RST;
            entry_rej_reg <= krm_pkg::ENTRY_REJ_RST;
            avg_rej_reg   <= krm_pkg::AVG_REJ_RST;
            fade_reg      <= krm_pkg::FADE_RST;
            complete_reg  <= krm_pkg::COMPLETE_RST;
            pat_lo_reg    <= krm_pkg::PATTERN_LO_RST;
            pat_hi_reg    <= krm_pkg::PATTERN_HI_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                krm_pkg::REG_THRESHOLD:  thr_reg       <= cfg_data[9:0];
                krm_pkg::REG_ENTRY_REJ:  entry_rej_reg <= cfg_data[6:0];
                krm_pkg::REG_AVG_REJ:    avg_rej_reg   <= cfg_data[6:0];
                krm_pkg::REG_FADE:       fade_reg      <= cfg_data[15:0];
                krm_pkg::REG_COMPLETE:   complete_reg  <= cfg_data[15:0];
                krm_pkg::REG_PATTERN_LO: pat_lo_reg    <= cfg_data[48:0];
                krm_pkg::REG_PATTERN_HI: pat_hi_reg    <= cfg_data[48:0];
                default: ;
            endcase
        end
    end

    // tick handling
    logic        accept;
    logic        hit;
    logic        opening;
    logic [31:0] gap;
    logic        recording;
    logic [INTERVAL_BITS-1:0] gap_sat;
    logic [IW-1:0] count_next;
    logic        ending;

    assign accept    = in_valid && !in_stall;
    assign hit       = (sample >= thr_reg);
    assign opening   = hit && !listening_reg;
    assign gap       = now_ms - last_reg;
    assign recording = listening_reg && hit && (gap > 32'(fade_reg))
                       && (count_reg < IW'(MAX_KNOCKS));
    assign gap_sat   = (gap > 32'({INTERVAL_BITS{1'b1}})) ? {INTERVAL_BITS{1'b1}}
                                                           : gap[INTERVAL_BITS-1:0];
    assign count_next = opening ? '0 : (recording ? count_reg + 1'b1 : count_reg);
    // after a knock that opens a session or records an interval the quiet time restarts from zero
    assign ending = (listening_reg || opening)
                    && ((((opening || recording) ? 32'd0 : gap) >= 32'(complete_reg))
                        || (count_next >= IW'(MAX_KNOCKS)));

    always_ff @(posedge clk)
    begin
        if (accept && opening)
        begin
            for (int i = 0; i < MAX_KNOCKS; i++)
            begin
                ist_reg[i] <= '0;
            end
            for (int i = 1; i <= MAX_KNOCKS; i++)
            begin
                sst_reg[i] <= '0;
            end
            sst_reg[0] <= sample;
        end
        else if (accept && recording)
        begin
            ist_reg[count_reg[IXW-1:0]] <= gap_sat;
            sst_reg[count_reg + 1'b1]   <= sample;
        end
    end

    // shared divider
    logic [INTERVAL_BITS-1:0] cur_iv;
    logic [6:0]               cur_pe;
    logic                     div_start;
    logic [6:0]               div_q;
    krm_pkg::div_stat_t       div_stat;

    assign cur_iv = (idx_reg < IW'(MAX_KNOCKS)) ? ist_reg[idx_reg[IXW-1:0]] : '0;
    assign cur_pe = krm_pkg::pattern_entry(pat_lo_reg, pat_hi_reg, 6'(idx_reg));
    assign div_start = (state_reg == S_DIV_START) && (cur_iv != '0);

    krm_div #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((INTERVAL_BITS+7)'(cur_iv) * (INTERVAL_BITS+7)'(krm_pkg::SCALE_TOP)),
        .divisor  (largest_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    logic [6:0]  diff;
    logic [IW:0] knocks;
    logic        normal;
    logic [7+IW:0] avg_lim;

    assign diff    = (scaled_reg > cur_pe) ? scaled_reg - cur_pe : cur_pe - scaled_reg;
    assign knocks  = {1'b0, count_reg} + 1'b1;
    assign normal  = (knocks > (IW+1)'(krm_pkg::NORMAL_MANY))
                     || ((knocks >= (IW+1)'(krm_pkg::NORMAL_FEW))
                         && (SUMW'(sum_reg) > SUMW'(12'(thr_reg) * 12'd3)));
    // floor(total / wanted) <= avg  is  total < (avg + 1) * wanted
    assign avg_lim = (8+IW)'({1'b0, avg_rej_reg} + 8'd1) * (8+IW)'(wanted_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            listening_reg   <= 1'b0;
            count_reg       <= '0;
            last_reg        <= '0;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= krm_pkg::VERDICT_REJECT;
            knock_count_reg <= '0;
            idx_reg         <= '0;
            heard_reg       <= '0;
            wanted_reg      <= '0;
            largest_reg     <= '0;
            sum_reg         <= '0;
            total_reg       <= '0;
            scaled_reg      <= '0;
            match_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        if (opening || recording)
                        begin
                            last_reg <= now_ms;
                        end
                        listening_reg <= (listening_reg || opening) && !ending;
                        if (ending)
                        begin
                            state_reg   <= S_SCAN;
                            idx_reg     <= '0;
                            heard_reg   <= '0;
                            wanted_reg  <= '0;
                            largest_reg <= '0;
                            sum_reg     <= '0;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg < IW'(MAX_KNOCKS))
                    begin
                        if (cur_iv != '0)
                        begin
                            heard_reg <= heard_reg + 1'b1;
                        end
                        if (cur_pe != '0)
                        begin
                            wanted_reg <= wanted_reg + 1'b1;
                        end
                        if (cur_iv > largest_reg)
                        begin
                            largest_reg <= cur_iv;
                        end
                    end
                    if ({1'b0, idx_reg} < knocks)
                    begin
                        sum_reg <= sum_reg + SUMW'(sst_reg[idx_reg]);
                    end
                    if (idx_reg == IW'(MAX_KNOCKS))
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_CHECK:
                begin
                    idx_reg   <= '0;
                    total_reg <= '0;
                    match_reg <= (heard_reg == wanted_reg) && (wanted_reg != '0)
                                 && (largest_reg != '0);
                    if ((heard_reg == wanted_reg) && (wanted_reg != '0)
                        && (largest_reg != '0))
                    begin
                        state_reg <= S_DIV_START;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIV_START:
                begin
                    if (cur_iv == '0)
                    begin
                        scaled_reg <= '0;
                        state_reg  <= S_ENTRY;
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        scaled_reg <= div_q;
                        state_reg  <= S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    if (diff > entry_rej_reg)
                    begin
                        match_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        total_reg <= total_reg + TW'(diff);
                        if (idx_reg == IW'(MAX_KNOCKS - 1))
                        begin
                            state_reg <= S_AVG;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_AVG:
                begin
                    match_reg <= ((8+IW)'(total_reg) < avg_lim);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        priority if (match_reg)
                        begin
                            verdict_reg <= krm_pkg::VERDICT_SECRET;
                        end
                        else if (normal)
                        begin
                            verdict_reg <= krm_pkg::VERDICT_NORMAL;
                        end
                        else
                        begin
                            verdict_reg <= krm_pkg::VERDICT_REJECT;
                        end
                        knock_count_reg <= (knocks > (IW+1)'(15)) ? 4'd15 : 4'(knocks);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV_WAIT))
        else $error("divider busy outside wait state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(MAX_KNOCKS))
        else $error("interval count past limit");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word loaded outside done state");
`endif

endmodule
